// ----- design/joystick_gait_command_mapper_core_defines.svh -----
// ---------------------------------------------------------------------------
// Joystick gait command mapper: assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_GAIT_COMMAND_MAPPER_CORE_DEFINES_SVH
`define JOYSTICK_GAIT_COMMAND_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define JGCM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JGCM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/jgcm_pkg.sv -----
// ---------------------------------------------------------------------------
// jgcm_pkg
// Types, constants and helper functions shared by the gait command mapper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jgcm_pkg;

  localparam int AXIS_BITS = 16;
  localparam int FRAC      = AXIS_BITS - 1;
  localparam int DB_BITS   = 15;
  localparam int DB_W      = (AXIS_BITS + 1 > DB_BITS) ? AXIS_BITS + 1 : DB_BITS;
  localparam int CMP_W     = (AXIS_BITS > 16) ? AXIS_BITS : 16;
  localparam int MA_W      = AXIS_BITS + 1;
  localparam int MB_W      = (AXIS_BITS + 1 > 17) ? AXIS_BITS + 1 : 17;
  localparam int P_W       = MA_W + MB_W;
  localparam int SPD_W     = 17;
  localparam int SPD_MAX   = 65535;
  localparam int LIM_W     = 48;
  localparam int IDX_W     = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_DEADBAND  = 3'd0,
    REG_GATE_THR  = 3'd1,
    REG_GATE_BLW  = 3'd2,
    REG_WALK_LIM  = 3'd3,
    REG_TROT_LIM  = 3'd4,
    REG_YAW_LIM   = 3'd5,
    REG_HGT_LIM   = 3'd6
  } jgcm_reg_e;

  typedef enum logic [1:0] {
    MODE_STAND = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_WALK  = 2'd2,
    MODE_TROT  = 2'd3
  } jgcm_mode_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_HEIGHT,
    OP_FWD,
    OP_LAT1,
    OP_YAW,
    OP_LAT2,
    OP_FIN
  } jgcm_op_e;

  typedef struct packed {
    logic     load;
    jgcm_op_e op;
  } jgcm_cmd_t;

  typedef struct packed {
    logic out_full;
  } jgcm_stat_t;

  // Zero an axis whose magnitude sits below the deadband.
  function automatic logic signed [AXIS_BITS-1:0] dead_f(
    input logic signed [AXIS_BITS-1:0] a,
    input logic [DB_BITS-1:0]          db
  );
    logic signed [AXIS_BITS:0] ax;
    logic [AXIS_BITS:0]        mag;
    ax  = (AXIS_BITS + 1)'(a);
    mag = ax[AXIS_BITS] ? $unsigned(-ax) : $unsigned(ax);
    return (DB_W'(mag) < DB_W'(db)) ? '0 : a;
  endfunction

  // Saturate to the speed range.
  function automatic logic signed [SPD_W-1:0] sat_f(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] hi;
    logic signed [P_W-1:0] lo;
    hi = P_W'(SPD_MAX);
    lo = P_W'(-SPD_MAX);
    if (v > hi) begin
      return SPD_W'(hi);
    end else if (v < lo) begin
      return SPD_W'(lo);
    end
    return SPD_W'(v);
  endfunction

endpackage

// ----- design/jgcm_ctrl.sv -----
// ---------------------------------------------------------------------------
// jgcm_ctrl
// Sequencer: walks one sample through the shared multiplier and hands the
// finished command to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jgcm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jgcm_pkg::jgcm_stat_t stat_i,
  output jgcm_pkg::jgcm_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEIGHT,
    S_FWD,
    S_LAT1,
    S_YAW,
    S_LAT2,
    S_FIN
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.load = in_valid_i && in_ready_o;
    unique case (state_q)
      S_IDLE:   cmd_o.op = jgcm_pkg::OP_IDLE;
      S_HEIGHT: cmd_o.op = jgcm_pkg::OP_HEIGHT;
      S_FWD:    cmd_o.op = jgcm_pkg::OP_FWD;
      S_LAT1:   cmd_o.op = jgcm_pkg::OP_LAT1;
      S_YAW:    cmd_o.op = jgcm_pkg::OP_YAW;
      S_LAT2:   cmd_o.op = jgcm_pkg::OP_LAT2;
      S_FIN:    cmd_o.op = jgcm_pkg::OP_FIN;
      default:  cmd_o.op = jgcm_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_HEIGHT;
        S_HEIGHT: state_q <= S_FWD;
        S_FWD:    state_q <= S_LAT1;
        S_LAT1:   state_q <= S_YAW;
        S_YAW:    state_q <= S_LAT2;
        S_LAT2:   state_q <= S_FIN;
        S_FIN:    if (!stat_i.out_full) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/jgcm_dp.sv -----
// ---------------------------------------------------------------------------
// jgcm_dp
// Datapath: configuration registers, sample capture, gait mode and height
// state, one shared registered multiplier and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jgcm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [jgcm_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [jgcm_pkg::LIM_W-1:0]            cfg_data_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_forward_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_lateral_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_height_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_yaw_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] gate_axis_i,
  input  logic [3:0]                            buttons_i,
  input  jgcm_pkg::jgcm_cmd_t                   cmd_i,
  output jgcm_pkg::jgcm_stat_t                  stat_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            gait_sel_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_forward_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_lateral_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_turn_o,
  output logic signed [15:0]                    body_height_o
);

  localparam int AB = jgcm_pkg::AXIS_BITS;
  localparam int MA = jgcm_pkg::MA_W;
  localparam int MB = jgcm_pkg::MB_W;
  localparam int PW = jgcm_pkg::P_W;
  localparam int CW = jgcm_pkg::CMP_W;
  localparam int SW = jgcm_pkg::SPD_W;

  // Configuration registers
  logic [jgcm_pkg::DB_BITS-1:0]   db_q;
  logic signed [15:0]             gate_thr_q;
  logic                           gate_blw_q;
  logic [jgcm_pkg::LIM_W-1:0]     walk_q;
  logic [jgcm_pkg::LIM_W-1:0]     trot_q;
  logic [15:0]                    yaw_lim_q;
  logic [jgcm_pkg::LIM_W-1:0]     hgt_lim_q;

  // State
  jgcm_pkg::jgcm_mode_e           mode_q;
  jgcm_pkg::jgcm_mode_e           mode_d;
  logic signed [15:0]             height_q;
  logic [3:0]                     last_btn_q;

  // Working registers
  logic signed [MA-1:0]           fwd_q;
  logic signed [MA-1:0]           lat_q;
  logic signed [MA-1:0]           hax_q;
  logic signed [MA-1:0]           yax_q;
  logic                           h_act_q;
  logic signed [MA-1:0]           shaped_q;
  logic signed [SW-1:0]           vx_q;
  logic signed [SW-1:0]           rate_q;
  logic signed [PW-1:0]           p_q;

  // Output register
  logic                           out_valid_q;
  jgcm_pkg::jgcm_mode_e           gait_q;
  logic signed [SW-1:0]           spd_fwd_q;
  logic signed [SW-1:0]           spd_lat_q;
  logic signed [SW-1:0]           yaw_out_q;
  logic signed [15:0]             hgt_out_q;

  logic signed [AB-1:0]           dfwd;
  logic signed [AB-1:0]           dlat;
  logic signed [AB-1:0]           dhgt;
  logic signed [AB-1:0]           dyaw;
  logic                           gate_open;
  logic [3:0]                     rise;
  logic [jgcm_pkg::LIM_W-1:0]     lim;
  logic signed [MA-1:0]           lat_abs;
  logic signed [MA-1:0]           op_a;
  logic signed [MB-1:0]           op_b;
  logic signed [PW-1:0]           sh;
  logic signed [PW-1:0]           h_new;
  logic signed [PW-1:0]           h_lo;
  logic signed [PW-1:0]           h_hi;
  logic                           moving;
  logic                           fin_load;

  assign dfwd = jgcm_pkg::dead_f(axis_forward_i, db_q);
  assign dlat = jgcm_pkg::dead_f(axis_lateral_i, db_q);
  assign dhgt = jgcm_pkg::dead_f(axis_height_i, db_q);
  assign dyaw = jgcm_pkg::dead_f(axis_yaw_i, db_q);

  assign gate_open = gate_blw_q ? (CW'(gate_axis_i) < CW'(gate_thr_q))
                                : (CW'(gate_axis_i) > CW'(gate_thr_q));
  assign rise = buttons_i & ~last_btn_q;

  always_comb begin
    mode_d = mode_q;
    if (gate_open) begin
      priority if (rise[3]) mode_d = jgcm_pkg::MODE_TROT;
      else if (rise[2])     mode_d = jgcm_pkg::MODE_WALK;
      else if (rise[1])     mode_d = jgcm_pkg::MODE_STEP;
      else if (rise[0])     mode_d = jgcm_pkg::MODE_STAND;
    end
  end

  assign lim     = (mode_q == jgcm_pkg::MODE_WALK) ? walk_q : trot_q;
  assign lat_abs = lat_q[MA-1] ? -lat_q : lat_q;
  assign sh      = p_q >>> jgcm_pkg::FRAC;

  always_comb begin
    unique case (cmd_i.op)
      jgcm_pkg::OP_HEIGHT: begin
        op_a = hax_q;
        op_b = $signed(MB'(hgt_lim_q[15:0]));
      end
      jgcm_pkg::OP_FWD: begin
        op_a = fwd_q;
        op_b = fwd_q[MA-1] ? $signed(MB'(lim[31:16])) : $signed(MB'(lim[15:0]));
      end
      jgcm_pkg::OP_LAT1: begin
        op_a = lat_q;
        op_b = MB'(lat_abs);
      end
      jgcm_pkg::OP_YAW: begin
        op_a = yax_q;
        op_b = $signed(MB'(yaw_lim_q));
      end
      jgcm_pkg::OP_LAT2: begin
        op_a = shaped_q;
        op_b = $signed(MB'(lim[47:32]));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Height step and clamp: lower bound first, then upper bound.
  always_comb begin
    h_lo  = PW'($signed(hgt_lim_q[31:16]));
    h_hi  = PW'($signed(hgt_lim_q[47:32]));
    h_new = PW'(height_q) - sh;
    if (h_new < h_lo) h_new = h_lo;
    if (h_new > h_hi) h_new = h_hi;
  end

  assign moving   = (mode_q == jgcm_pkg::MODE_WALK) || (mode_q == jgcm_pkg::MODE_TROT);
  assign fin_load = (cmd_i.op == jgcm_pkg::OP_FIN) && !stat_o.out_full;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q       <= jgcm_pkg::DB_BITS'(2621);
      gate_thr_q <= -16'sd16384;
      gate_blw_q <= 1'b1;
      walk_q     <= '0;
      trot_q     <= '0;
      yaw_lim_q  <= 16'd22938;
      hgt_lim_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jgcm_pkg::REG_DEADBAND: db_q       <= cfg_data_i[jgcm_pkg::DB_BITS-1:0];
        jgcm_pkg::REG_GATE_THR: gate_thr_q <= $signed(cfg_data_i[15:0]);
        jgcm_pkg::REG_GATE_BLW: gate_blw_q <= cfg_data_i[0];
        jgcm_pkg::REG_WALK_LIM: walk_q     <= cfg_data_i;
        jgcm_pkg::REG_TROT_LIM: trot_q     <= cfg_data_i;
        jgcm_pkg::REG_YAW_LIM:  yaw_lim_q  <= cfg_data_i[15:0];
        jgcm_pkg::REG_HGT_LIM:  hgt_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= jgcm_pkg::MODE_STAND;
      height_q    <= '0;
      last_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mode_q     <= mode_d;
        last_btn_q <= buttons_i;
      end
      if ((cmd_i.op == jgcm_pkg::OP_FWD) && h_act_q) begin
        height_q <= h_new[15:0];
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Hold the lateral product while the final step waits on the output.
    if (cmd_i.op != jgcm_pkg::OP_FIN) p_q <= PW'(op_a) * PW'(op_b);
    if (cmd_i.load) begin
      fwd_q   <= MA'(dfwd);
      lat_q   <= -MA'(dlat);
      hax_q   <= MA'(dhgt);
      yax_q   <= MA'(dyaw);
      h_act_q <= (dhgt != '0);
    end
    if (cmd_i.op == jgcm_pkg::OP_LAT1) vx_q     <= jgcm_pkg::sat_f(sh);
    if (cmd_i.op == jgcm_pkg::OP_YAW)  shaped_q <= sh[MA-1:0];
    if (cmd_i.op == jgcm_pkg::OP_LAT2) rate_q   <= jgcm_pkg::sat_f(sh);
    if (fin_load) begin
      gait_q    <= mode_q;
      spd_fwd_q <= moving ? vx_q : '0;
      spd_lat_q <= moving ? jgcm_pkg::sat_f(sh) : '0;
      yaw_out_q <= (mode_q != jgcm_pkg::MODE_STAND) ? rate_q : '0;
      hgt_out_q <= height_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gait_sel_o      = gait_q;
  assign speed_forward_o = spd_fwd_q;
  assign speed_lateral_o = spd_lat_q;
  assign speed_turn_o    = yaw_out_q;
  assign body_height_o   = hgt_out_q;

endmodule

// ----- design/joystick_gait_command_mapper_core.sv -----
// ---------------------------------------------------------------------------
// joystick_gait_command_mapper_core
// Maps one joystick sample to a gait mode, velocity and height command.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat per joystick
//   sample: five Q1.15 axes and four buttons. Output channel
//   (out_valid_o / out_ready_i) returns one command beat per sample.
//   Configuration is a plain write port: cfg_we_i, cfg_idx_i, cfg_data_i;
//   write only while the block is idle.
//   A sample is captured, then steps through the height, forward, lateral,
//   yaw and second lateral products, which take turns on the single shared
//   multiplier, and is handed to the output register in the final step.
//   in_ready_o is high only while the sequencer is idle; a new sample is
//   taken while the previous command still waits in the output register.
//   Receiver stall: the sequencer holds in its final step until the output
//   register frees, then takes the next sample.
//   Reset: registers return to their reset values, mode to stand, height
//   offset and button history to zero, and the output register empties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joystick_gait_command_mapper_core_defines.svh"

module joystick_gait_command_mapper_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [jgcm_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [jgcm_pkg::LIM_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_forward_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_lateral_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_height_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] axis_yaw_i,
  input  logic signed [jgcm_pkg::AXIS_BITS-1:0] gate_axis_i,
  input  logic [3:0]                            buttons_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            gait_sel_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_forward_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_lateral_o,
  output logic signed [jgcm_pkg::SPD_W-1:0]     speed_turn_o,
  output logic signed [15:0]                    body_height_o
);

  jgcm_pkg::jgcm_cmd_t  cmd;
  jgcm_pkg::jgcm_stat_t stat;

  jgcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  jgcm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .axis_forward_i  (axis_forward_i),
    .axis_lateral_i  (axis_lateral_i),
    .axis_height_i   (axis_height_i),
    .axis_yaw_i      (axis_yaw_i),
    .gate_axis_i     (gate_axis_i),
    .buttons_i       (buttons_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .gait_sel_o      (gait_sel_o),
    .speed_forward_o (speed_forward_o),
    .speed_lateral_o (speed_lateral_o),
    .speed_turn_o    (speed_turn_o),
    .body_height_o   (body_height_o)
  );

  `JGCM_ASSERT_NXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o, "ready after beat")
  `JGCM_ASSERT_IMP(a_ready_only_idle, in_ready_o, cmd.op == jgcm_pkg::OP_IDLE, "ready while busy")
  `JGCM_ASSERT_NXT(a_fin_fills_out, (cmd.op == jgcm_pkg::OP_FIN) && !stat.out_full, out_valid_o, "command lost")

endmodule

// ----- bench/joystick_gait_command_mapper_core_test.sv -----
// ---------------------------------------------------------------------------
// joystick_gait_command_mapper_core_test
// Drives joystick samples through the valid/ready input channel and checks
// every command beat against a local model of the gait state, deadband,
// speed scaling and height clamp. Register settings change between phases
// while the block is idle. Both channels idle at random, and one long
// receiver hold fills the block so that it stalls its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_gait_command_mapper_core_test;
  import jgcm_pkg::*;

  localparam logic signed [AXIS_BITS-1:0] AX_MIN   = 16'sh8000;
  localparam logic signed [AXIS_BITS-1:0] AX_MAX   = 16'sh7fff;
  localparam logic [3:0]                  BTN_STAND = 4'h1;
  localparam logic [3:0]                  BTN_STEP  = 4'h2;
  localparam logic [3:0]                  BTN_WALK  = 4'h4;
  localparam logic [3:0]                  BTN_TROT  = 4'h8;
  localparam logic [IDX_W-1:0]            REG_NONE  = 3'd7;
  localparam int                          LONG_HOLD = 300;
  localparam int                          RAND_PER_PHASE = 125;

  typedef struct {
    logic signed [AXIS_BITS-1:0] fwd;
    logic signed [AXIS_BITS-1:0] lat;
    logic signed [AXIS_BITS-1:0] hgt;
    logic signed [AXIS_BITS-1:0] yaw;
    logic signed [AXIS_BITS-1:0] gate;
    logic [3:0]                  btn;
  } joy_t;

  typedef struct {
    logic [1:0]              mode;
    logic signed [SPD_W-1:0] vx;
    logic signed [SPD_W-1:0] vy;
    logic signed [SPD_W-1:0] wz;
    logic signed [15:0]      hgt;
  } gait_cmd_t;

  logic                          clk      = 1'b0;
  logic                          rst_n    = 1'b0;
  logic                          cfg_we   = 1'b0;
  logic [IDX_W-1:0]              cfg_idx  = '0;
  logic [LIM_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [AXIS_BITS-1:0]   ax_fwd   = '0;
  logic signed [AXIS_BITS-1:0]   ax_lat   = '0;
  logic signed [AXIS_BITS-1:0]   ax_hgt   = '0;
  logic signed [AXIS_BITS-1:0]   ax_yaw   = '0;
  logic signed [AXIS_BITS-1:0]   ax_gate  = '0;
  logic [3:0]                    btns     = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    gait_sel;
  logic signed [SPD_W-1:0]       spd_fwd;
  logic signed [SPD_W-1:0]       spd_lat;
  logic signed [SPD_W-1:0]       spd_turn;
  logic signed [15:0]            hgt_off;

  // Model copy of the registers and the gait state
  logic [14:0]        cfg_db    = 15'd2621;
  logic signed [15:0] cfg_thr   = -16'sd16384;
  logic               cfg_blw   = 1'b1;
  logic [47:0]        cfg_walk  = '0;
  logic [47:0]        cfg_trot  = '0;
  logic [15:0]        cfg_yaw   = 16'd22938;
  logic [47:0]        cfg_hgt   = '0;
  jgcm_mode_e         gait_now  = MODE_STAND;
  logic signed [15:0] hgt_now   = '0;
  logic [3:0]         prev_btn  = '0;

  joy_t       sample_queue[$];
  gait_cmd_t  cmd_expected[$];
  joy_t       cur_joy;
  gait_cmd_t  due_cmd;
  logic [3:0] last_btn_gen = '0;
  int         samples_queued = 0;
  int         cmds_checked   = 0;
  int         n_fail         = 0;
  int         n_cfg_writes   = 0;
  int         mode_hits[4]   = '{0, 0, 0, 0};
  int         send_wait      = 0;
  int         recv_wait      = 0;
  int         hold_left      = 0;
  int         rcv_draw;
  int         drv_gap_max    = 5;
  int         rcv_gap_max    = 5;
  logic       press_arm      = 1'b0;
  logic       press_taken    = 1'b0;

  always #5 clk = ~clk;

  joystick_gait_command_mapper_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .axis_forward_i  (ax_fwd),
    .axis_lateral_i  (ax_lat),
    .axis_height_i   (ax_hgt),
    .axis_yaw_i      (ax_yaw),
    .gate_axis_i     (ax_gate),
    .buttons_i       (btns),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .gait_sel_o      (gait_sel),
    .speed_forward_o (spd_fwd),
    .speed_lateral_o (spd_lat),
    .speed_turn_o    (spd_turn),
    .body_height_o   (hgt_off)
  );

  function automatic longint deadzone(input logic signed [AXIS_BITS-1:0] a);
    longint v;
    v = a;
    return ((v < 0 ? -v : v) < longint'(cfg_db)) ? 0 : v;
  endfunction

  function automatic longint clamp_speed(input longint v);
    if (v > SPD_MAX) return SPD_MAX;
    if (v < -SPD_MAX) return -SPD_MAX;
    return v;
  endfunction

  function automatic gait_cmd_t map_joy(input joy_t s);
    gait_cmd_t  r;
    longint     fx, ly, hz, wy, gt, st, lo, hi, hn, mag, shaped, vx, vy, wz;
    logic [47:0] lim;
    logic [3:0]  rise;
    logic        open;
    fx = deadzone(s.fwd);
    ly = -deadzone(s.lat);
    hz = deadzone(s.hgt);
    wy = deadzone(s.yaw);
    gt = s.gate;
    if (hz != 0) begin
      st = longint'(cfg_hgt[15:0]);
      lo = longint'($signed(cfg_hgt[31:16]));
      hi = longint'($signed(cfg_hgt[47:32]));
      hn = longint'(hgt_now) - ((hz * st) >>> FRAC);
      if (hn < lo) hn = lo;
      if (hn > hi) hn = hi;
      hgt_now = 16'(hn);
    end
    open = cfg_blw ? (gt < longint'(cfg_thr)) : (gt > longint'(cfg_thr));
    rise = s.btn & ~prev_btn;
    if (open) begin
      for (int b = 0; b < 4; b++) begin
        if (rise[b]) gait_now = jgcm_mode_e'(2'(b));
      end
    end
    prev_btn = s.btn;
    vx = 0;
    vy = 0;
    wz = 0;
    if (gait_now == MODE_WALK || gait_now == MODE_TROT) begin
      lim    = (gait_now == MODE_WALK) ? cfg_walk : cfg_trot;
      mag    = (ly < 0) ? -ly : ly;
      shaped = (ly * mag) >>> FRAC;
      vx = clamp_speed((fx * (fx >= 0 ? longint'(lim[15:0]) : longint'(lim[31:16]))) >>> FRAC);
      vy = clamp_speed((shaped * longint'(lim[47:32])) >>> FRAC);
    end
    if (gait_now != MODE_STAND) wz = clamp_speed((wy * longint'(cfg_yaw)) >>> FRAC);
    r.mode = gait_now;
    r.vx   = SPD_W'(vx);
    r.vy   = SPD_W'(vy);
    r.wz   = SPD_W'(wz);
    r.hgt  = hgt_now;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Drive one sample beat at a time from the pending queue
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) cmd_expected.push_back(map_joy(cur_joy));
      if (!in_valid || in_ready) begin
        if (send_wait == 0 && sample_queue.size() != 0) begin
          cur_joy   = sample_queue.pop_front();
          ax_fwd    <= cur_joy.fwd;
          ax_lat    <= cur_joy.lat;
          ax_hgt    <= cur_joy.hgt;
          ax_yaw    <= cur_joy.yaw;
          ax_gate   <= cur_joy.gate;
          btns      <= cur_joy.btn;
          in_valid  <= 1'b1;
          send_wait <= $urandom_range(0, drv_gap_max);
        end else begin
          in_valid <= 1'b0;
          if (send_wait != 0) send_wait <= send_wait - 1;
        end
      end
    end
  end

  // Take command beats and check them in order
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        cmds_checked++;
        if (cmd_expected.size() == 0) begin
          $error("command beat with no sample outstanding");
          n_fail++;
        end else begin
          due_cmd = cmd_expected.pop_front();
          compare_field("gait_sel", due_cmd.mode, gait_sel);
          compare_field("speed_forward", due_cmd.vx, spd_fwd);
          compare_field("speed_lateral", due_cmd.vy, spd_lat);
          compare_field("speed_turn", due_cmd.wz, spd_turn);
          compare_field("body_height", due_cmd.hgt, hgt_off);
          mode_hits[gait_sel]++;
        end
      end
      if (press_arm && !press_taken) begin
        press_taken <= 1'b1;
        hold_left   <= LONG_HOLD;
        out_ready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        rcv_draw = $urandom_range(0, rcv_gap_max);
        out_ready <= (rcv_draw == 0);
        recv_wait <= rcv_draw;
      end else if (!out_ready) begin
        if (recv_wait == 0) out_ready <= 1'b1;
        else recv_wait <= recv_wait - 1;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg_writes++;
    case (idx)
      REG_DEADBAND: cfg_db   = val[14:0];
      REG_GATE_THR: cfg_thr  = val[15:0];
      REG_GATE_BLW: cfg_blw  = val[0];
      REG_WALK_LIM: cfg_walk = val;
      REG_TROT_LIM: cfg_trot = val;
      REG_YAW_LIM:  cfg_yaw  = val[15:0];
      REG_HGT_LIM:  cfg_hgt  = val;
      default: ;
    endcase
  endtask

  task automatic push_joy(input logic signed [AXIS_BITS-1:0] f, l, h, y, g,
                          input logic [3:0] b);
    joy_t j;
    j.fwd  = f;
    j.lat  = l;
    j.hgt  = h;
    j.yaw  = y;
    j.gate = g;
    j.btn  = b;
    sample_queue.push_back(j);
    samples_queued++;
    last_btn_gen = b;
  endtask

  task automatic drain();
    while (cmds_checked < samples_queued) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] lim_pack(input int fwd, input int bwd, input int vy);
    return {16'(vy), 16'(bwd), 16'(fwd)};
  endfunction

  function automatic logic [47:0] hgt_pack(input int step, input int lo, input int hi);
    return {16'(hi), 16'(lo), 16'(step)};
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] pick_axis();
    logic [AXIS_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = AX_MIN;
      1: v = AX_MAX;
      2: begin
        v = 16'(cfg_db) + 16'($urandom_range(0, 2)) - 16'd1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: v = '0;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] pick_gate();
    longint t;
    if (cfg_blw) t = longint'(cfg_thr) - 1 - int'($urandom_range(0, 2000));
    else t = longint'(cfg_thr) + 1 + int'($urandom_range(0, 2000));
    if ($urandom_range(0, 3) == 0 || t < -32768 || t > 32767) return 16'($urandom);
    return 16'(t);
  endfunction

  function automatic logic [3:0] pick_buttons();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ($urandom_range(0, 1) == 1) ? BTN_TROT : BTN_WALK;
      2: return 4'($urandom);
      default: return last_btn_gen;
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic signed [AXIS_BITS-1:0] g_open;
    logic signed [AXIS_BITS-1:0] g_shut;
    g_open = AX_MIN;
    g_shut = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values
    push_joy(0, 0, 0, 0, g_shut, BTN_STEP);
    push_joy(AX_MAX, AX_MIN, AX_MAX, AX_MAX, g_open, BTN_STEP);
    push_joy(0, 0, 0, AX_MIN, g_open, 4'h0);
    push_joy(0, 0, 0, AX_MIN, g_open, BTN_STEP);
    push_joy(2620, 2620, 0, 2620, g_open, BTN_STEP);
    push_joy(0, 0, 0, 2621, g_open, BTN_STEP);
    drain();

    write_reg(REG_DEADBAND, 48'd1000);
    write_reg(REG_GATE_THR, 48'(-16'sd16384));
    write_reg(REG_GATE_BLW, 48'd1);
    write_reg(REG_WALK_LIM, lim_pack(50000, 30000, 40000));
    write_reg(REG_TROT_LIM, lim_pack(65535, 65535, 65535));
    write_reg(REG_YAW_LIM, 48'd65535);
    write_reg(REG_HGT_LIM, hgt_pack(12000, -20000, 20000));

    push_joy(0, 0, 0, 0, g_open, BTN_STEP | BTN_WALK | BTN_TROT);
    push_joy(AX_MAX, AX_MIN, 0, AX_MAX, g_open, BTN_TROT);
    push_joy(AX_MIN, AX_MAX, 0, AX_MIN, g_open, BTN_TROT);
    push_joy(999, -999, 999, 999, g_open, BTN_TROT);
    push_joy(1000, -1000, 1000, -1000, g_open, BTN_TROT);
    push_joy(0, 0, AX_MIN, 0, g_open, 4'h0);
    push_joy(0, 0, AX_MIN, 0, g_open, 4'h0);
    push_joy(0, 0, AX_MIN, 0, g_open, 4'h0);
    for (int k = 0; k < 4; k++) push_joy(0, 0, AX_MAX, 0, g_open, 4'h0);
    push_joy(16000, 16000, 0, 16000, g_open, BTN_WALK);
    push_joy(-16000, -16000, 0, -16000, g_shut, BTN_WALK | BTN_STAND);
    push_joy(16000, -16000, 0, 16000, g_open, BTN_WALK | BTN_STAND);
    push_joy(16000, 16000, 0, 16000, g_open, 4'h0);
    push_joy(16000, 16000, 0, 16000, g_open, BTN_STAND);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DEADBAND, 48'd0);
          write_reg(REG_GATE_THR, 48'(AX_MIN));
          write_reg(REG_GATE_BLW, 48'd0);
          write_reg(REG_WALK_LIM, '1);
          write_reg(REG_TROT_LIM, '0);
          write_reg(REG_YAW_LIM, 48'd65535);
          write_reg(REG_HGT_LIM, hgt_pack(65535, -32768, 32767));
        end
        1: begin
          write_reg(REG_DEADBAND, 48'd32767);
          write_reg(REG_GATE_THR, 48'(AX_MAX));
          write_reg(REG_GATE_BLW, 48'd1);
          write_reg(REG_WALK_LIM, rnd48());
          write_reg(REG_TROT_LIM, '1);
          write_reg(REG_YAW_LIM, 48'd0);
          write_reg(REG_HGT_LIM, hgt_pack($urandom_range(0, 65535), 5000, -5000));
        end
        3: begin
          write_reg(REG_DEADBAND, 48'd500);
          write_reg(REG_GATE_THR, 48'd0);
          write_reg(REG_GATE_BLW, 48'd0);
          write_reg(REG_WALK_LIM, rnd48());
          write_reg(REG_HGT_LIM, hgt_pack($urandom_range(0, 4000), -3000, 3000));
        end
        5: begin
          write_reg(REG_DEADBAND, 48'd2621);
          write_reg(REG_GATE_THR, 48'(-16'sd16384));
          write_reg(REG_GATE_BLW, 48'd1);
          write_reg(REG_WALK_LIM, lim_pack($urandom_range(0, 65535), $urandom_range(0, 65535),
                                           $urandom_range(0, 65535)));
          write_reg(REG_TROT_LIM, rnd48());
          write_reg(REG_YAW_LIM, 48'd22938);
          write_reg(REG_HGT_LIM, hgt_pack(2000, -10000, 10000));
        end
        default: begin
          write_reg(REG_DEADBAND, {33'($urandom), 15'($urandom_range(0, 4000))});
          write_reg(REG_GATE_THR, rnd48());
          write_reg(REG_GATE_BLW, rnd48());
          write_reg(REG_WALK_LIM, rnd48());
          write_reg(REG_TROT_LIM, rnd48());
          write_reg(REG_YAW_LIM, rnd48());
          write_reg(REG_HGT_LIM, rnd48());
          write_reg(REG_NONE, rnd48());
        end
      endcase
      drv_gap_max = (ph == 1 || ph == 4) ? 0 : 5;
      rcv_gap_max = (ph == 4) ? 0 : 5;
      if (ph == 1) press_arm = 1'b1;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        push_joy(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_gate(),
                 pick_buttons());
      end
      drain();
    end

    if (cmd_expected.size() != 0) begin
      $error("%0d commands never arrived", cmd_expected.size());
      n_fail++;
    end
    $display("Covered %0d samples across %0d register writes, one long output hold.",
             samples_queued, n_cfg_writes);
    $display("Commands seen per gait: stand %0d, stepping %0d, walk %0d, trot %0d.",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
